// ===== design/ipspd_pkg.sv =====
// Package for the IPsec security policy table lookup block.
// Holds the item types, the policy record, the control codes and the sizing constants.
// No dependencies.
`default_nettype none
package ipspd_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_SET_SA  = 2'd2,
    ACT_LOOKUP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    VERDICT_BYPASS = 2'd0
  } verdict_code_t;

  typedef enum logic {
    DIR_OUTBOUND = 1'b0
  } dir_code_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] vrf;
    logic [31:0] policy_id;
    logic [15:0] priority_req;
    logic        direction;
    logic [1:0]  verdict;
    logic [31:0] dst_low;
    logic [31:0] dst_high;
    logic [7:0]  proto_low;
    logic [7:0]  proto_high;
    logic [15:0] sa_handle;
    logic [39:0] packet_selector;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        matched;
    logic [1:0]  result_verdict;
    logic [15:0] result_sa;
  } out_t;

  typedef struct packed {
    logic [15:0] vrf;
    logic [31:0] id;
    logic        dir;
    logic [15:0] prio;
    logic [1:0]  verdict;
    logic [31:0] dst_lo;
    logic [31:0] dst_hi;
    logic [7:0]  pr_lo;
    logic [7:0]  pr_hi;
    logic [15:0] sa;
  } policy_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_PLACE,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic start_shift;
    logic shift;
    logic place;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic             scan_done;
    logic             shift_done;
    logic             err;
    logic [1:0]       action;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/ipsec_policy_table_lookup.sv =====
// Ordered security policy table: create, destroy, set-SA and lookup, one request at a time.
// An operation first walks the held policies through the slot memory, one slot a cycle,
// and create or destroy then moves the entries behind the insert or removal point one
// slot a cycle. The result sits in an output register, so a new request is taken while
// the last result waits. Reset clears the entry count, the valid flags and the controller
// state; there is no clearing pass over the slot memory.
// Depends on ipspd_pkg, ipspd_ctrl and ipspd_dp.
`default_nettype none
module ipsec_policy_table_lookup (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ipspd_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ipspd_pkg::out_t      out_data
);

  ipspd_pkg::cmd_t cmd;
  ipspd_pkg::sts_t sts;
  logic            idle;

  assign in_stall = !idle;

  ipspd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  ipspd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sts.count <= ipspd_pkg::CNT_W'(ipspd_pkg::ENTRIES))
    else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("beat taken while previous request still in work");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (sts.count == $past(sts.count) ||
                     sts.count == $past(sts.count) + ipspd_pkg::CNT_W'(1) ||
                     sts.count == $past(sts.count) - ipspd_pkg::CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in work");

endmodule
`default_nettype wire

// ===== design/ipspd_ctrl.sv =====
// Controller state machine for the policy table: sequences scan, shift, place and respond.
// Depends on ipspd_pkg.
`default_nettype none
module ipspd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire ipspd_pkg::sts_t   sts,
  output ipspd_pkg::cmd_t        cmd,
  output logic                   idle
);

  ipspd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipspd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ipspd_pkg::ST_IDLE: begin
        if (in_valid) state_next = ipspd_pkg::ST_SCAN;
      end
      ipspd_pkg::ST_SCAN: begin
        if (sts.scan_done) state_next = ipspd_pkg::ST_DECIDE;
      end
      ipspd_pkg::ST_DECIDE: begin
        if (sts.err || sts.action == ipspd_pkg::ACT_LOOKUP) begin
          state_next = ipspd_pkg::ST_RESPOND;
        end else if (sts.action == ipspd_pkg::ACT_SET_SA) begin
          state_next = ipspd_pkg::ST_PLACE;
        end else begin
          state_next = ipspd_pkg::ST_SHIFT;
        end
      end
      ipspd_pkg::ST_SHIFT: begin
        if (sts.shift_done) state_next = ipspd_pkg::ST_PLACE;
      end
      ipspd_pkg::ST_PLACE: begin
        state_next = ipspd_pkg::ST_RESPOND;
      end
      ipspd_pkg::ST_RESPOND: begin
        if (sts.out_free) state_next = ipspd_pkg::ST_IDLE;
      end
      default: state_next = ipspd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state)
      ipspd_pkg::ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = in_valid;
      end
      ipspd_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ipspd_pkg::ST_DECIDE: begin
        cmd.decide      = 1'b1;
        cmd.start_shift = !sts.err && (sts.action == ipspd_pkg::ACT_CREATE ||
                                       sts.action == ipspd_pkg::ACT_DESTROY);
      end
      ipspd_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
      end
      ipspd_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
      end
      ipspd_pkg::ST_RESPOND: begin
        cmd.respond = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ipspd_dp.sv =====
// Datapath for the policy table: slot memory, entry count, scan compare and result register.
// Depends on ipspd_pkg.
`default_nettype none
module ipspd_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ipspd_pkg::in_t    in_data,
  input  wire ipspd_pkg::cmd_t   cmd,
  input  wire logic              out_stall,
  output ipspd_pkg::sts_t        sts,
  output logic                   out_valid,
  output ipspd_pkg::out_t        out_data
);

  localparam int IW = ipspd_pkg::IDX_W;
  localparam int CW = ipspd_pkg::CNT_W;

  ipspd_pkg::policy_t mem [ipspd_pkg::ENTRIES];
  ipspd_pkg::policy_t rdata;
  ipspd_pkg::policy_t hit;
  ipspd_pkg::policy_t wdata;
  ipspd_pkg::in_t     item;

  logic [CW-1:0] count;
  logic [CW-1:0] ridx;
  logic [CW-1:0] at;
  logic [CW-1:0] sj;
  logic [IW-1:0] pidx;
  logic [IW-1:0] fpos;
  logic [IW-1:0] wtgt;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic          rv, wpend, found, atfound, lfound, err;
  logic [1:0]    lverd;
  logic [15:0]   lsa;
  logic          scan_issue, shift_issue, re, we, err_now, is_create;
  logic [31:0]   pkt_dst;
  logic [7:0]    pkt_proto;

  assign is_create  = item.action == ipspd_pkg::ACT_CREATE;
  assign pkt_dst    = item.packet_selector[39:8];
  assign pkt_proto  = item.packet_selector[7:0];
  assign scan_issue = cmd.scan && (ridx < count);
  assign shift_issue = cmd.shift && (is_create ? (sj > at) : ((sj + CW'(1)) < count));
  assign re = scan_issue || shift_issue;

  always_comb begin
    raddr = ridx[IW-1:0];
    if (cmd.shift) begin
      raddr = is_create ? IW'(sj - CW'(1)) : IW'(sj + CW'(1));
    end
  end

  // Shift moves are written in the cycle after their read; place writes the new or updated slot.
  always_comb begin
    we    = wpend;
    waddr = wtgt;
    wdata = rdata;
    if (cmd.place && is_create) begin
      we    = 1'b1;
      waddr = at[IW-1:0];
      wdata = '{vrf: item.vrf, id: item.policy_id, dir: item.direction,
                prio: item.priority_req, verdict: item.verdict,
                dst_lo: item.dst_low, dst_hi: item.dst_high,
                pr_lo: item.proto_low, pr_hi: item.proto_high, sa: 16'd0};
    end else if (cmd.place && item.action == ipspd_pkg::ACT_SET_SA) begin
      we       = 1'b1;
      waddr    = fpos;
      wdata    = hit;
      wdata.sa = item.sa_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_comb begin
    case (item.action)
      ipspd_pkg::ACT_CREATE: err_now = found || (count == CW'(ipspd_pkg::ENTRIES));
      ipspd_pkg::ACT_LOOKUP: err_now = 1'b0;
      default:               err_now = !found;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rv        <= 1'b0;
      wpend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rv    <= scan_issue;
      wpend <= shift_issue;
      if (cmd.place && is_create) begin
        count <= count + CW'(1);
      end else if (cmd.place && item.action == ipspd_pkg::ACT_DESTROY) begin
        count <= count - CW'(1);
      end
      if (cmd.respond) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= in_data;
      ridx    <= '0;
      found   <= 1'b0;
      atfound <= 1'b0;
      lfound  <= 1'b0;
      at      <= count;
    end
    if (scan_issue) begin
      ridx <= ridx + CW'(1);
      pidx <= ridx[IW-1:0];
    end
    if (rv) begin
      if (!found && rdata.vrf == item.vrf && rdata.id == item.policy_id) begin
        found <= 1'b1;
        fpos  <= pidx;
        hit   <= rdata;
      end
      if (!atfound && rdata.dir == item.direction && rdata.prio >= item.priority_req) begin
        atfound <= 1'b1;
        at      <= {1'b0, pidx};
      end
      if (!lfound && rdata.dir == item.direction && rdata.vrf == item.vrf &&
          pkt_dst >= rdata.dst_lo && pkt_dst <= rdata.dst_hi &&
          pkt_proto >= rdata.pr_lo && pkt_proto <= rdata.pr_hi) begin
        lfound <= 1'b1;
        lverd  <= rdata.verdict;
        lsa    <= rdata.sa;
      end
    end
    if (cmd.decide) err <= err_now;
    if (cmd.start_shift) sj <= is_create ? count : {1'b0, fpos};
    if (shift_issue) begin
      wtgt <= sj[IW-1:0];
      sj   <= is_create ? sj - CW'(1) : sj + CW'(1);
    end
    if (cmd.respond) begin
      out_data.status         <= err;
      out_data.matched        <= 1'b0;
      out_data.result_verdict <= ipspd_pkg::VERDICT_BYPASS;
      out_data.result_sa      <= '0;
      if (item.action == ipspd_pkg::ACT_LOOKUP && lfound) begin
        out_data.matched        <= 1'b1;
        out_data.result_verdict <= lverd;
        if (item.direction == ipspd_pkg::DIR_OUTBOUND) out_data.result_sa <= lsa;
      end
    end
  end

  assign sts.scan_done  = (ridx >= count) && !rv;
  assign sts.shift_done = !shift_issue && !wpend;
  assign sts.err        = err_now;
  assign sts.action     = item.action;
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.count      = count;

endmodule
`default_nettype wire
